// ----- sv/nps_pkg.sv -----
// Shared types and constants of the nine-patch shadow layout block.
`default_nettype none

package nps_pkg;

  localparam int WIN_W  = 14;
  localparam int OFS_W  = 13;
  localparam int RAD_W  = 7;
  localparam int OPA_W  = 8;
  localparam int DST_W  = 16;
  localparam int SRC_W  = 25;
  localparam int SLEN_W = 24;
  localparam int IDX_W  = 5;
  localparam int CFG_W  = 7;

  localparam int NBANDS = 5;
  localparam int NCELLS = 25;
  localparam int NCAND  = 9;
  localparam int QDEPTH = 2;
  localparam int CNT_W  = 3;
  localparam int BIDX_W = 3;
  localparam int POS_W  = 17;

  localparam int DEF_MAX_BLUR  = 64;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCELLS - 1);

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    CFG_SHADOW_ENABLE = 2'd0,
    CFG_BLUR_RADIUS   = 2'd1,
    CFG_DRAW_UNDER    = 2'd2
  } cfg_idx_e;

  // one band straight out of the axis cutter, middle quotients still pending
  typedef struct packed {
    logic signed [DST_W-1:0] dst;
    logic [WIN_W-1:0]        len;
    logic                    over;
    logic                    mid;
    logic [WIN_W-1:0]        num;
    logic [SRC_W-1:0]        csrc;
    logic [SLEN_W-1:0]       cslen;
  } cut_band_t;

  typedef struct packed {
    cut_band_t [NBANDS-1:0] band;
    logic [CNT_W-1:0]       n;
    logic [WIN_W-1:0]       div;
  } cut_t;

  typedef struct packed {
    logic signed [DST_W-1:0] dst;
    logic [WIN_W-1:0]        len;
    logic [SRC_W-1:0]        src;
    logic [SLEN_W-1:0]       slen;
    logic                    over;
  } band_t;

  typedef struct packed {
    band_t [NBANDS-1:0] col;
    band_t [NBANDS-1:0] row;
    logic [CNT_W-1:0]   nc;
    logic [CNT_W-1:0]   nr;
    logic [OPA_W-1:0]   opacity;
    logic               under;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic                    live;
    logic signed [DST_W-1:0] dest_x;
    logic signed [DST_W-1:0] dest_y;
    logic [WIN_W-1:0]        dest_w;
    logic [WIN_W-1:0]        dest_h;
    logic [SRC_W-1:0]        source_x;
    logic [SRC_W-1:0]        source_y;
    logic [SLEN_W-1:0]       source_w;
    logic [SLEN_W-1:0]       source_h;
    logic [OPA_W-1:0]        opacity;
    logic                    last;
  } cell_t;

endpackage

`default_nettype wire

// ----- sv/nps_axis_cut.sv -----
// Cuts one axis into up to five bands and packs them in order.
`default_nettype none

module nps_axis_cut #(
  parameter int FRAC_BITS = nps_pkg::DEF_FRAC_BITS
) (
  input  logic [nps_pkg::WIN_W-1:0]        size_i,
  input  logic [nps_pkg::RAD_W-1:0]        radius_i,
  input  logic signed [nps_pkg::OFS_W-1:0] offset_i,
  output nps_pkg::cut_t                    cut_o
);

  localparam int WIDE_W = nps_pkg::SRC_W + FRAC_BITS;
  localparam int PAD_S  = nps_pkg::POS_W - nps_pkg::WIN_W;
  localparam int PAD_R  = nps_pkg::POS_W - nps_pkg::RAD_W;
  localparam int PAD_E  = nps_pkg::POS_W - nps_pkg::WIN_W + 1;
  localparam int PAD_O  = nps_pkg::POS_W - nps_pkg::OFS_W;

  logic [nps_pkg::WIN_W-2:0] half;
  logic [nps_pkg::WIN_W-2:0] reach;
  nps_pkg::pos_t s_p, r_p, o_p, e_p;
  nps_pkg::pos_t lo [3];
  nps_pkg::pos_t ln [3];
  nps_pkg::pos_t b2;
  logic [9:0] base [3];

  nps_pkg::pos_t c_start [nps_pkg::NCAND];
  nps_pkg::pos_t c_stop  [nps_pkg::NCAND];
  nps_pkg::pos_t c_len   [nps_pkg::NCAND];
  nps_pkg::pos_t c_d     [nps_pkg::NCAND];
  nps_pkg::pos_t c_midp  [nps_pkg::NCAND];
  logic          c_ok    [nps_pkg::NCAND];
  logic [WIDE_W-1:0] c_src_w  [nps_pkg::NCAND];
  logic [WIDE_W-1:0] c_slen_w [nps_pkg::NCAND];
  nps_pkg::cut_band_t cand [nps_pkg::NCAND];

  assign half  = size_i[nps_pkg::WIN_W-1:1];
  assign reach = ((nps_pkg::WIN_W-1)'(radius_i) < half) ? (nps_pkg::WIN_W-1)'(radius_i) : half;
  assign s_p   = {{PAD_S{1'b0}}, size_i};
  assign r_p   = {{PAD_R{1'b0}}, radius_i};
  assign e_p   = {{PAD_E{1'b0}}, reach};
  assign o_p   = {{PAD_O{offset_i[nps_pkg::OFS_W-1]}}, offset_i};

  // leading corner, stretched middle, trailing corner
  assign lo[0] = o_p - r_p;
  assign ln[0] = r_p + e_p;
  assign lo[1] = o_p + e_p;
  assign ln[1] = s_p - e_p - e_p;
  assign lo[2] = o_p + s_p - e_p;
  assign ln[2] = r_p + e_p;
  assign b2    = r_p + r_p + r_p + nps_pkg::pos_t'(1) - e_p;
  assign base[0] = '0;
  assign base[1] = '0;
  assign base[2] = b2[9:0];

  always_comb begin
    nps_pkg::pos_t hi;
    logic in0, in1, ok;
    for (int i = 0; i < 3; i++) begin
      hi  = lo[i] + ln[i];
      in0 = (lo[i] < 0) && (hi > 0);
      in1 = (lo[i] < s_p) && (hi > s_p);
      ok  = ln[i] > 0;
      c_start[3*i]   = lo[i];
      c_stop[3*i]    = in0 ? nps_pkg::pos_t'(0) : (in1 ? s_p : hi);
      c_ok[3*i]      = ok;
      c_start[3*i+1] = in0 ? nps_pkg::pos_t'(0) : s_p;
      c_stop[3*i+1]  = (in0 && in1) ? s_p : hi;
      c_ok[3*i+1]    = ok && (in0 || in1);
      c_start[3*i+2] = s_p;
      c_stop[3*i+2]  = hi;
      c_ok[3*i+2]    = ok && in0 && in1;
    end
  end

  always_comb begin
    for (int c = 0; c < nps_pkg::NCAND; c++) begin
      c_len[c]    = c_stop[c] - c_start[c];
      c_d[c]      = c_start[c] - lo[c/3];
      c_midp[c]   = c_start[c] + (c_len[c] >>> 1);
      c_src_w[c]  = (WIDE_W'(base[c/3]) + WIDE_W'(c_d[c][9:0])) << FRAC_BITS;
      c_slen_w[c] = WIDE_W'(c_len[c][nps_pkg::WIN_W-1:0]) << FRAC_BITS;
      cand[c].dst   = c_start[c][nps_pkg::DST_W-1:0];
      cand[c].len   = c_len[c][nps_pkg::WIN_W-1:0];
      cand[c].over  = (c_midp[c] >= 0) && (c_midp[c] < s_p);
      cand[c].mid   = (c / 3) == 1;
      cand[c].num   = c_d[c][nps_pkg::WIN_W-1:0];
      cand[c].csrc  = c_src_w[c][nps_pkg::SRC_W-1:0];
      cand[c].cslen = c_slen_w[c][nps_pkg::SLEN_W-1:0];
    end
  end

  // pack live candidates in order
  always_comb begin
    logic [3:0] cnt;
    cnt   = '0;
    cut_o = '0;
    for (int c = 0; c < nps_pkg::NCAND; c++) begin
      if (c_ok[c] && (cnt < 4'(nps_pkg::NBANDS))) begin
        cut_o.band[cnt[2:0]] = cand[c];
        cnt = cnt + 4'd1;
      end
    end
    cut_o.n   = cnt[nps_pkg::CNT_W-1:0];
    cut_o.div = ln[1][nps_pkg::WIN_W-1:0];
  end

endmodule

`default_nettype wire

// ----- sv/nps_front.sv -----
// Front end: takes an item, cuts both axes and runs the middle-band dividers.
`default_nettype none

module nps_front #(
  parameter int MAX_BLUR  = nps_pkg::DEF_MAX_BLUR,
  parameter int FRAC_BITS = nps_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [nps_pkg::WIN_W-1:0]        window_width_i,
  input  logic [nps_pkg::WIN_W-1:0]        window_height_i,
  input  logic signed [nps_pkg::OFS_W-1:0] offset_x_i,
  input  logic signed [nps_pkg::OFS_W-1:0] offset_y_i,
  input  logic [nps_pkg::OPA_W-1:0]        opacity_i,
  input  logic                             shadow_enable_i,
  input  logic [nps_pkg::RAD_W-1:0]        blur_radius_i,
  input  logic                             draw_under_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output nps_pkg::job_t                    push_data_o
);

  localparam int STEP_W = $clog2(FRAC_BITS + 1);
  localparam int WIDE_W = nps_pkg::SRC_W + FRAC_BITS;
  localparam int W      = nps_pkg::WIN_W;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_LOAD = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  front_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic accept;

  logic [W-1:0] w_q, h_q;
  logic signed [nps_pkg::OFS_W-1:0] ox_q, oy_q;
  logic [nps_pkg::OPA_W-1:0] op_q;
  logic [nps_pkg::RAD_W-1:0] r_q;
  logic live_q, under_q;

  nps_pkg::cut_t cut [2];

  // lane 0 divides the offset into the middle slice, lane 1 the band length
  logic [W-1:0]         rem_q [2][nps_pkg::NBANDS][2];
  logic [W-1:0]         rem_d [2][nps_pkg::NBANDS][2];
  logic [FRAC_BITS:0]   quo_q [2][nps_pkg::NBANDS][2];
  logic [FRAC_BITS:0]   quo_d [2][nps_pkg::NBANDS][2];
  logic [W:0]           trial [2][nps_pkg::NBANDS][2];
  logic [WIDE_W-1:0]    msrc  [2][nps_pkg::NBANDS];
  logic [WIDE_W-1:0]    mslen [2][nps_pkg::NBANDS];

  nps_axis_cut #(.FRAC_BITS(FRAC_BITS)) u_cut_x (
    .size_i  (w_q),
    .radius_i(r_q),
    .offset_i(ox_q),
    .cut_o   (cut[0])
  );

  nps_axis_cut #(.FRAC_BITS(FRAC_BITS)) u_cut_y (
    .size_i  (h_q),
    .radius_i(r_q),
    .offset_i(oy_q),
    .cut_o   (cut[1])
  );

  assign push_valid_o = state_q == F_PUSH;
  assign in_ready_o   = (state_q == F_IDLE) || ((state_q == F_PUSH) && push_ready_i);
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_LOAD;
      end
      F_LOAD: state_d = F_DIV;
      F_DIV: begin
        if (step_q == STEP_W'(FRAC_BITS)) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready_i) state_d = accept ? F_LOAD : F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_DIV) step_q <= step_q + STEP_W'(1);
      else                  step_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q     <= window_width_i;
      h_q     <= window_height_i;
      ox_q    <= offset_x_i;
      oy_q    <= offset_y_i;
      op_q    <= opacity_i;
      under_q <= draw_under_i;
      live_q  <= shadow_enable_i && (opacity_i != '0) &&
                 (window_width_i != '0) && (window_height_i != '0);
      if ({1'b0, blur_radius_i} > 8'(MAX_BLUR)) r_q <= nps_pkg::RAD_W'(MAX_BLUR);
      else                                       r_q <= blur_radius_i;
    end
  end

  // restoring division, one quotient bit per lane and cycle
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < nps_pkg::NBANDS; b++) begin
        for (int k = 0; k < 2; k++) begin
          trial[a][b][k] = (step_q == '0) ? {1'b0, rem_q[a][b][k]} : {rem_q[a][b][k], 1'b0};
          if (state_q == F_LOAD) begin
            rem_d[a][b][k] = (k == 0) ? cut[a].band[b].num : cut[a].band[b].len;
            quo_d[a][b][k] = '0;
          end else if (trial[a][b][k] >= {1'b0, cut[a].div}) begin
            rem_d[a][b][k] = W'(trial[a][b][k] - {1'b0, cut[a].div});
            quo_d[a][b][k] = {quo_q[a][b][k][FRAC_BITS-1:0], 1'b1};
          end else begin
            rem_d[a][b][k] = trial[a][b][k][W-1:0];
            quo_d[a][b][k] = {quo_q[a][b][k][FRAC_BITS-1:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == F_LOAD) || (state_q == F_DIV)) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    nps_pkg::band_t bd;
    push_data_o = '0;
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < nps_pkg::NBANDS; b++) begin
        msrc[a][b]  = (WIDE_W'(r_q) << (FRAC_BITS + 1)) + WIDE_W'(quo_q[a][b][0]);
        mslen[a][b] = WIDE_W'(quo_q[a][b][1]);
        bd.dst  = cut[a].band[b].dst;
        bd.len  = cut[a].band[b].len;
        bd.over = cut[a].band[b].over;
        if (cut[a].band[b].mid) begin
          bd.src  = msrc[a][b][nps_pkg::SRC_W-1:0];
          bd.slen = mslen[a][b][nps_pkg::SLEN_W-1:0];
        end else begin
          bd.src  = cut[a].band[b].csrc;
          bd.slen = cut[a].band[b].cslen;
        end
        if (a == 0) push_data_o.col[b] = bd;
        else        push_data_o.row[b] = bd;
      end
    end
    push_data_o.nc      = live_q ? cut[0].n : '0;
    push_data_o.nr      = live_q ? cut[1].n : '0;
    push_data_o.opacity = op_q;
    push_data_o.under   = under_q;
  end

endmodule

`default_nettype wire

// ----- sv/nps_fifo.sv -----
// Small job queue between the front end and the cell emitter.
`default_nettype none

module nps_fifo #(
  parameter int DEPTH = nps_pkg::QDEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  nps_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output nps_pkg::job_t pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nps_pkg::job_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// ----- sv/nps_back.sv -----
// Back end: walks the band cross product and emits the 25 cell results.
`default_nettype none

module nps_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  nps_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output nps_pkg::cell_t out_o
);

  logic [nps_pkg::BIDX_W-1:0] x_q, y_q;
  logic [nps_pkg::IDX_W-1:0]  idx_q;
  logic scan_done_q;
  logic out_valid_q;
  nps_pkg::cell_t out_q, out_d;

  logic can_load, active, in_scan, hide, x_end, y_end, emit;
  nps_pkg::band_t colb, rowb;

  assign can_load = !out_valid_q || out_ready_i;
  assign active   = head_valid_i && can_load;
  assign in_scan  = !scan_done_q && (head_i.nc != '0) && (head_i.nr != '0);
  assign colb     = head_i.col[x_q];
  assign rowb     = head_i.row[y_q];
  assign hide     = !head_i.under && colb.over && rowb.over;
  assign x_end    = x_q == head_i.nc - nps_pkg::CNT_W'(1);
  assign y_end    = y_q == head_i.nr - nps_pkg::CNT_W'(1);
  assign emit     = active && !(in_scan && hide);
  assign pop_o    = emit && (idx_q == nps_pkg::LAST_IDX);

  always_comb begin
    out_d       = '0;
    out_d.index = idx_q;
    out_d.last  = idx_q == nps_pkg::LAST_IDX;
    if (in_scan) begin
      out_d.live     = 1'b1;
      out_d.dest_x   = colb.dst;
      out_d.dest_y   = rowb.dst;
      out_d.dest_w   = colb.len;
      out_d.dest_h   = rowb.len;
      out_d.source_x = colb.src;
      out_d.source_y = rowb.src;
      out_d.source_w = colb.slen;
      out_d.source_h = rowb.slen;
      out_d.opacity  = head_i.opacity;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      idx_q       <= '0;
      scan_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (can_load) out_valid_q <= emit;
      if (pop_o) begin
        x_q         <= '0;
        y_q         <= '0;
        idx_q       <= '0;
        scan_done_q <= 1'b0;
      end else if (active) begin
        if (emit) idx_q <= idx_q + nps_pkg::IDX_W'(1);
        if (in_scan) begin
          if (x_end) begin
            x_q <= '0;
            y_q <= y_q + nps_pkg::BIDX_W'(1);
            if (y_end) scan_done_q <= 1'b1;
          end else begin
            x_q <= x_q + nps_pkg::BIDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load && emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && in_scan |-> (x_q < head_i.nc) && (y_q < head_i.nr))
    else $error("band walk left the band table");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && out_q.last && (out_q.index == nps_pkg::LAST_IDX))
    else $error("job released without its final cell");

  a_live_has_opacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.live |-> (out_q.opacity != '0) && (out_q.dest_w != '0))
    else $error("live cell without opacity or width");

endmodule

`default_nettype wire

// ----- sv/nine_patch_shadow_layout.sv -----
// Top level of the nine-patch shadow layout block.
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o  | window size, shadow offset, opacity
//  out     | out_valid_o / out_ready_i| one cell: index, live, dest, source, last
//  cfg     | cfg_we_i (no wait)       | cfg_index_i selects, cfg_data_i writes
//
// Every item yields 25 cells, one per cycle from the emitter while the output
// is not stalled; the walk also spends a step on each cell hidden under the
// window, and that walk sets the sustained rate. The front end's middle-band
// dividers make one quotient bit per cycle; it runs ahead through a 2-deep queue.
// Reset clears config, queue and control state; no clearing pass is needed.
// A stalled output only stops the emitter; the front keeps filling the queue.
`default_nettype none

module nine_patch_shadow_layout #(
  parameter int MAX_BLUR  = nps_pkg::DEF_MAX_BLUR,
  parameter int FRAC_BITS = nps_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [nps_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [nps_pkg::WIN_W-1:0]         window_width_i,
  input  logic [nps_pkg::WIN_W-1:0]         window_height_i,
  input  logic signed [nps_pkg::OFS_W-1:0]  offset_x_i,
  input  logic signed [nps_pkg::OFS_W-1:0]  offset_y_i,
  input  logic [nps_pkg::OPA_W-1:0]         opacity_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nps_pkg::IDX_W-1:0]         cell_index_o,
  output logic                              cell_live_o,
  output logic signed [nps_pkg::DST_W-1:0]  dest_x_o,
  output logic signed [nps_pkg::DST_W-1:0]  dest_y_o,
  output logic [nps_pkg::WIN_W-1:0]         dest_w_o,
  output logic [nps_pkg::WIN_W-1:0]         dest_h_o,
  output logic [nps_pkg::SRC_W-1:0]         source_x_o,
  output logic [nps_pkg::SRC_W-1:0]         source_y_o,
  output logic [nps_pkg::SLEN_W-1:0]        source_w_o,
  output logic [nps_pkg::SLEN_W-1:0]        source_h_o,
  output logic [nps_pkg::OPA_W-1:0]         cell_opacity_o,
  output logic                              last_o
);

  // configuration registers
  logic                      shadow_enable_q;
  logic [nps_pkg::RAD_W-1:0] blur_radius_q;
  logic                      draw_under_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_enable_q <= 1'b0;
      blur_radius_q   <= '0;
      draw_under_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (nps_pkg::cfg_idx_e'(cfg_index_i))
        nps_pkg::CFG_SHADOW_ENABLE: shadow_enable_q <= cfg_data_i[0];
        nps_pkg::CFG_BLUR_RADIUS:   blur_radius_q   <= cfg_data_i;
        nps_pkg::CFG_DRAW_UNDER:    draw_under_q    <= cfg_data_i[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  logic          push_valid, push_ready, head_valid, pop;
  nps_pkg::job_t push_data, head;
  nps_pkg::cell_t out_cell;

  // front: accept, cut axes, divide middle bands
  nps_front #(
    .MAX_BLUR (MAX_BLUR),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .window_width_i (window_width_i),
    .window_height_i(window_height_i),
    .offset_x_i     (offset_x_i),
    .offset_y_i     (offset_y_i),
    .opacity_i      (opacity_i),
    .shadow_enable_i(shadow_enable_q),
    .blur_radius_i  (blur_radius_q),
    .draw_under_i   (draw_under_q),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  // decoupling queue
  nps_fifo #(.DEPTH(nps_pkg::QDEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (head_valid),
    .pop_i       (pop),
    .pop_data_o  (head)
  );

  // back: live cells first, then dead fill up to 25
  nps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_cell)
  );

  assign cell_index_o   = out_cell.index;
  assign cell_live_o    = out_cell.live;
  assign dest_x_o       = out_cell.dest_x;
  assign dest_y_o       = out_cell.dest_y;
  assign dest_w_o       = out_cell.dest_w;
  assign dest_h_o       = out_cell.dest_h;
  assign source_x_o     = out_cell.source_x;
  assign source_y_o     = out_cell.source_y;
  assign source_w_o     = out_cell.source_w;
  assign source_h_o     = out_cell.source_h;
  assign cell_opacity_o = out_cell.opacity;
  assign last_o         = out_cell.last;

endmodule

`default_nettype wire
